/* rtl/core/drh_pkg.sv */
// Package for the DTLS record header parser: field widths, header offsets,
// status and kind codes, the header snapshot type and the message-type map.
// No dependencies.
package drh_pkg;

  localparam int unsigned HEADER_BYTES = 13;
  localparam int unsigned CountW = 17;

  localparam logic [CountW-1:0] COUNT_MAX   = '1;
  localparam logic [CountW-1:0] HDR_LEN     = CountW'(HEADER_BYTES);
  localparam logic [CountW-1:0] POS_TYPE    = CountW'(0);
  localparam logic [CountW-1:0] POS_VER_HI  = CountW'(1);
  localparam logic [CountW-1:0] POS_VER_LO  = CountW'(2);
  localparam logic [CountW-1:0] POS_EPO_HI  = CountW'(3);
  localparam logic [CountW-1:0] POS_EPO_LO  = CountW'(4);
  localparam logic [CountW-1:0] POS_LEN_HI  = CountW'(11);
  localparam logic [CountW-1:0] POS_LEN_LO  = CountW'(12);
  localparam logic [CountW-1:0] POS_BODY    = CountW'(HEADER_BYTES);

  localparam logic [7:0] TYPE_MIN     = 8'd20;
  localparam logic [7:0] TYPE_MAX     = 8'd63;
  localparam logic [7:0] TYPE_KNOWN   = 8'd23;
  localparam logic [7:0] VER_HI_DTLS  = 8'hFE;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_BAD_TYPE = 3'd2,
    ST_UNSUP    = 3'd3,
    ST_BAD_VER  = 3'd4,
    ST_TRUNC    = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    CK_CCS       = 3'd0,
    CK_ALERT     = 3'd1,
    CK_HANDSHAKE = 3'd2,
    CK_APPDATA   = 3'd3,
    CK_UNKNOWN   = 3'd4
  } content_kind_e;

  typedef enum logic [3:0] {
    HS_HELLO_REQUEST  = 4'd0,
    HS_CLIENT_HELLO   = 4'd1,
    HS_SERVER_HELLO   = 4'd2,
    HS_HELLO_VERIFY   = 4'd3,
    HS_CERTIFICATE    = 4'd4,
    HS_SERVER_KEY_EX  = 4'd5,
    HS_CERT_REQUEST   = 4'd6,
    HS_SERVER_DONE    = 4'd7,
    HS_CERT_VERIFY    = 4'd8,
    HS_CLIENT_KEY_EX  = 4'd9,
    HS_FINISHED       = 4'd10,
    HS_UNKNOWN        = 4'd11
  } hs_kind_e;

  // Header as it stands once the last byte of a datagram is in.
  typedef struct packed {
    logic [7:0]        type_byte;
    logic [15:0]       version_word;
    logic [15:0]       epoch_word;
    logic [15:0]       length_word;
    logic [7:0]        body_byte;
    logic [CountW-1:0] total;
  } hdr_t;

  function automatic hs_kind_e hs_map(input logic [7:0] v);
    case (v) inside
      8'd0, 8'd1, 8'd2, 8'd3: return hs_kind_e'(v[3:0]);
      [8'd11:8'd16]:          return hs_kind_e'(4'(v - 8'd7));
      8'd20:                  return HS_FINISHED;
      default:                return HS_UNKNOWN;
    endcase
  endfunction

endpackage

/* rtl/core/drh_capture.sv */
// Byte counter and header capture for the DTLS record header parser.
// Holds the header snapshot of a finished datagram; depends on drh_pkg.
module drh_capture import drh_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       snap_valid_o,
  input  logic       snap_ready_i,
  output hdr_t       snap_o
);

  logic [CountW-1:0] count_q, count_d, count_inc;
  logic [7:0]        type_q, type_d;
  logic [15:0]       ver_q, ver_d;
  logic [15:0]       epo_q, epo_d;
  logic [15:0]       len_q, len_d;
  logic [7:0]        body_q, body_d;
  logic              snap_valid_q;
  hdr_t              snap_q;
  logic              accept;

  assign in_ready_o = !snap_valid_q || snap_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign count_inc  = (count_q == COUNT_MAX) ? count_q : count_q + 1'b1;

  // Merge the incoming byte into the header at its offset.
  always_comb begin
    type_d = type_q;
    ver_d  = ver_q;
    epo_d  = epo_q;
    len_d  = len_q;
    body_d = body_q;
    unique case (count_q)
      POS_TYPE:   type_d       = data_byte_i;
      POS_VER_HI: ver_d[15:8]  = data_byte_i;
      POS_VER_LO: ver_d[7:0]   = data_byte_i;
      POS_EPO_HI: epo_d[15:8]  = data_byte_i;
      POS_EPO_LO: epo_d[7:0]   = data_byte_i;
      POS_LEN_HI: len_d[15:8]  = data_byte_i;
      POS_LEN_LO: len_d[7:0]   = data_byte_i;
      POS_BODY:   body_d       = data_byte_i;
      default: ;
    endcase
    count_d = count_inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      type_q  <= '0;
      ver_q   <= '0;
      epo_q   <= '0;
      len_q   <= '0;
      body_q  <= '0;
    end else if (accept) begin
      if (last_byte_i) begin
        count_q <= '0;
        type_q  <= '0;
        ver_q   <= '0;
        epo_q   <= '0;
        len_q   <= '0;
        body_q  <= '0;
      end else begin
        count_q <= count_d;
        type_q  <= type_d;
        ver_q   <= ver_d;
        epo_q   <= epo_d;
        len_q   <= len_d;
        body_q  <= body_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      snap_valid_q <= accept && last_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && last_byte_i) begin
      snap_q.type_byte    <= type_d;
      snap_q.version_word <= ver_d;
      snap_q.epoch_word   <= epo_d;
      snap_q.length_word  <= len_d;
      snap_q.body_byte    <= body_d;
      snap_q.total        <= count_d;
    end
  end

  assign snap_valid_o = snap_valid_q;
  assign snap_o       = snap_q;

endmodule

/* rtl/core/drh_classify.sv */
// Header checks and field decode for the DTLS record header parser,
// ending in the result register; depends on drh_pkg.
module drh_classify import drh_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          snap_valid_i,
  output logic          snap_ready_o,
  input  hdr_t          snap_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output status_e       status_o,
  output logic          demux_match_o,
  output content_kind_e content_kind_o,
  output logic [15:0]   version_field_o,
  output logic [15:0]   epoch_field_o,
  output logic [15:0]   body_length_o,
  output logic [16:0]   record_bytes_o,
  output hs_kind_e      handshake_kind_o
);

  logic              out_valid_q;
  logic              load;
  logic [CountW-1:0] rec;
  logic              long_enough, type_ok, ver_ok, fits;
  status_e           status_d;
  content_kind_e     kind_d;
  hs_kind_e          hs_d;

  assign snap_ready_o = !out_valid_q || out_ready_i;
  assign load         = snap_valid_i && snap_ready_o;

  assign rec         = HDR_LEN + CountW'(snap_i.length_word);
  assign long_enough = snap_i.total >= HDR_LEN;
  assign type_ok     = (snap_i.type_byte >= TYPE_MIN) && (snap_i.type_byte <= TYPE_MAX);
  assign ver_ok      = snap_i.version_word[15:8] == VER_HI_DTLS;
  assign fits        = rec <= snap_i.total;

  // First failing check wins.
  always_comb begin
    if (!long_enough)                        status_d = ST_SHORT;
    else if (!type_ok)                       status_d = ST_BAD_TYPE;
    else if (snap_i.type_byte > TYPE_KNOWN)  status_d = ST_UNSUP;
    else if (!ver_ok)                        status_d = ST_BAD_VER;
    else if (!fits)                          status_d = ST_TRUNC;
    else                                     status_d = ST_OK;
  end

  always_comb begin
    kind_d = content_kind_e'(3'(snap_i.type_byte - TYPE_MIN));
    hs_d   = HS_UNKNOWN;
    if (kind_d == CK_HANDSHAKE && snap_i.length_word != '0 && snap_i.total > HDR_LEN) begin
      hs_d = hs_map(snap_i.body_byte);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (snap_ready_o) begin
      out_valid_q <= snap_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      status_o      <= status_d;
      demux_match_o <= long_enough && type_ok && ver_ok && fits;
      if (status_d == ST_OK) begin
        content_kind_o   <= kind_d;
        version_field_o  <= snap_i.version_word;
        epoch_field_o    <= snap_i.epoch_word;
        body_length_o    <= snap_i.length_word;
        record_bytes_o   <= rec;
        handshake_kind_o <= hs_d;
      end else begin
        content_kind_o   <= CK_UNKNOWN;
        version_field_o  <= '0;
        epoch_field_o    <= '0;
        body_length_o    <= '0;
        record_bytes_o   <= '0;
        handshake_kind_o <= HS_UNKNOWN;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/core/dtls_record_header_parser.sv */
// Top level of the DTLS record header parser: byte capture and header decode.
// Depends on drh_pkg, drh_capture and drh_classify.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one datagram byte per
//   transfer in data_byte_i, with last_byte_i high on the final byte.
//   The output channel (out_valid_o / out_ready_i) carries one result per
//   datagram: status, DTLS demux verdict and the decoded header fields.
//   Bytes that are not last produce no result.
// Throughput: one byte per cycle while in_ready_o is high, in the capture
//   stage; consecutive datagrams may follow with no gap.
// Result path: after the transfer of its last byte, a datagram's result passes
//   the header snapshot register, then the result register.
// Reset: clears the byte counter, the captured header and both valid flags;
//   the next byte is taken as offset zero of a new datagram.
// Stall: while out_ready_i is low a pending result holds; the snapshot
//   register fills behind it, after which in_ready_o drops until the result
//   is taken. Fields of a failed datagram read zero, kinds read unknown.
module dtls_record_header_parser import drh_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    data_byte_i,
  input  logic          last_byte_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output status_e       status_o,
  output logic          demux_match_o,
  output content_kind_e content_kind_o,
  output logic [15:0]   version_field_o,
  output logic [15:0]   epoch_field_o,
  output logic [15:0]   body_length_o,
  output logic [16:0]   record_bytes_o,
  output hs_kind_e      handshake_kind_o
);

  // Header snapshot of the datagram that just ended.
  logic snap_valid, snap_ready;
  hdr_t snap;

  drh_capture u_capture (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .snap_valid_o (snap_valid),
    .snap_ready_i (snap_ready),
    .snap_o       (snap)
  );

  // Run the ordered checks and hold the result until the transfer.
  drh_classify u_classify (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .snap_valid_i     (snap_valid),
    .snap_ready_o     (snap_ready),
    .snap_i           (snap),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .demux_match_o    (demux_match_o),
    .content_kind_o   (content_kind_o),
    .version_field_o  (version_field_o),
    .epoch_field_o    (epoch_field_o),
    .body_length_o    (body_length_o),
    .record_bytes_o   (record_bytes_o),
    .handshake_kind_o (handshake_kind_o)
  );

endmodule

/* rtl/core/drh_checker.sv */
// Port-level checks for the DTLS record header parser, bound to the top level.
// Depends on drh_pkg.
module drh_port_checker import drh_pkg::*; (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input status_e       status_o,
  input logic          demux_match_o,
  input content_kind_e content_kind_o,
  input logic [15:0]   body_length_o,
  input logic [16:0]   record_bytes_o,
  input hs_kind_e      handshake_kind_o
);

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(record_bytes_o))
    else $error("stalled result changed");

  // Failed datagrams report unknown kinds and zero size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> content_kind_o == CK_UNKNOWN
      && handshake_kind_o == HS_UNKNOWN && record_bytes_o == '0)
    else $error("error result carries fields");

  // Good records size as header plus body and pass the demux.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_OK |-> demux_match_o
      && record_bytes_o == 17'(body_length_o) + 17'(HEADER_BYTES))
    else $error("ok result inconsistent");

  // Demux accepts only good records or unsupported in-range types.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && demux_match_o |-> status_o == ST_OK || status_o == ST_UNSUP)
    else $error("demux verdict contradicts status");

endmodule

bind dtls_record_header_parser drh_port_checker u_drh_checker (.*);
